>>> rtl/multi_queue_fifo_with_address_search_unit_macros.svh
// Assertion macros shared by the multi-queue FIFO RTL.
`ifndef MULTI_QUEUE_FIFO_WITH_ADDRESS_SEARCH_UNIT_MACROS_SVH
`define MULTI_QUEUE_FIFO_WITH_ADDRESS_SEARCH_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MQF_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MQF_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/mqf_pkg.sv
// Types and codes shared by the multi-queue FIFO modules.
package mqf_pkg;

  localparam logic [1:0] REQ_PUSH = 2'd0;
  localparam logic [1:0] REQ_POP  = 2'd1;
  localparam logic [1:0] REQ_PEEK = 2'd2;
  localparam logic [1:0] REQ_FIND = 2'd3;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_DISABLED = 2'd1;
  localparam logic [1:0] STAT_EMPTY    = 2'd2;
  localparam logic [1:0] STAT_FULL     = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [1:0]  queue_id;
    logic [31:0] address;
    logic [15:0] tag;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [31:0] out_address;
    logic [15:0] out_tag;
    logic [3:0]  position;
    logic [4:0]  count;
  } out_item_t;

  typedef struct packed {
    logic [31:0] address;
    logic [15:0] tag;
  } slot_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SEARCH,
    S_DONE
  } state_t;

endpackage

>>> rtl/mqf_slot_ram.sv
// Slot store: one write port and one read port with registered read data.
module mqf_slot_ram import mqf_pkg::*; #(
  parameter int SLOTS = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(SLOTS)-1:0] waddr,
  input  slot_t                    wdata,
  input  logic                     re,
  input  logic [$clog2(SLOTS)-1:0] raddr,
  output slot_t                    rdata
);

  slot_t slot_mem [SLOTS];
  slot_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      slot_mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= slot_mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/mqf_ctrl.sv
// Request sequencer: queue pointers, enable register and the slot search walk.
`include "multi_queue_fifo_with_address_search_unit_macros.svh"

module mqf_ctrl import mqf_pkg::*; #(
  parameter int NUM_QUEUES  = 4,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_valid,
  output logic                                       in_stall,
  input  in_item_t                                   in_data,
  input  logic                                       cfg_we,
  input  logic [3:0]                                 cfg_wdata,
  output logic                                       ram_we,
  output logic [$clog2(NUM_QUEUES*QUEUE_DEPTH)-1:0]  ram_waddr,
  output slot_t                                      ram_wdata,
  output logic                                       ram_re,
  output logic [$clog2(NUM_QUEUES*QUEUE_DEPTH)-1:0]  ram_raddr,
  input  slot_t                                      ram_rdata,
  output logic                                       res_valid,
  input  logic                                       res_ready,
  output out_item_t                                  res_data
);

  localparam int SLOT_W = $clog2(NUM_QUEUES * QUEUE_DEPTH);
  localparam int HEAD_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int QID_W  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam logic [HEAD_W:0]  RING_LEN = (HEAD_W + 1)'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  state_t                state_r, state_nxt;
  logic [3:0]            en_r, en_nxt;
  logic [HEAD_W-1:0]     head_r [NUM_QUEUES];
  logic [HEAD_W-1:0]     head_nxt [NUM_QUEUES];
  logic [CNT_W-1:0]      cnt_r [NUM_QUEUES];
  logic [CNT_W-1:0]      cnt_nxt [NUM_QUEUES];
  logic [QID_W-1:0]      q_r, q_nxt;
  logic [HEAD_W-1:0]     hsnap_r, hsnap_nxt;
  logic [HEAD_W-1:0]     cur_r, cur_nxt;
  logic [31:0]           key_r, key_nxt;
  logic [CNT_W-1:0]      cnt_q_r, cnt_q_nxt;
  out_item_t             res_r, res_nxt;

  logic                  in_acc;
  logic                  q_ok;
  logic                  en_hit;
  logic [QID_W-1:0]      qi;
  logic [HEAD_W-1:0]     hd;
  logic [CNT_W-1:0]      n;
  logic                  empty;
  logic                  full;
  logic                  srch_hit;
  logic                  srch_last;
  logic [NUM_QUEUES-1:0] rise;

  function automatic logic [HEAD_W-1:0] ring_add(input logic [HEAD_W-1:0] h,
                                                 input logic [HEAD_W-1:0] off);
    logic [HEAD_W:0] sum;
    sum = {1'b0, h} + {1'b0, off};
    if (sum >= RING_LEN) begin
      sum = sum - RING_LEN;
    end
    return sum[HEAD_W-1:0];
  endfunction

  function automatic logic [SLOT_W-1:0] slot_of(input logic [QID_W-1:0] qs,
                                                input logic [HEAD_W-1:0] h,
                                                input logic [HEAD_W-1:0] off);
    return SLOT_W'(qs * QUEUE_DEPTH) + SLOT_W'(ring_add(h, off));
  endfunction

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign q_ok      = (int'(in_data.queue_id) < NUM_QUEUES);
  assign en_hit    = q_ok && en_r[in_data.queue_id];
  assign qi        = QID_W'(in_data.queue_id);
  assign hd        = head_r[qi];
  assign n         = cnt_r[qi];
  assign empty     = (n == '0);
  assign full      = (n == CNT_FULL);
  assign srch_hit  = (ram_rdata.address == key_r);
  assign srch_last = (cur_r == '0);
  assign rise      = NUM_QUEUES'(cfg_wdata & ~en_r);
  assign res_valid = (state_r == S_DONE);
  assign res_data  = res_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (!en_hit) begin
            state_nxt = S_DONE;
          end else begin
            case (in_data.req_type)
              REQ_POP, REQ_PEEK: state_nxt = empty ? S_DONE : S_READ;
              REQ_FIND:          state_nxt = empty ? S_DONE : S_SEARCH;
              default:           state_nxt = S_DONE;
            endcase
          end
        end
      end
      S_READ: state_nxt = S_DONE;
      S_SEARCH: begin
        if (srch_hit || srch_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot_of(qi, hd, HEAD_W'(n));
    ram_wdata = '{address: in_data.address, tag: in_data.tag};
    ram_re    = 1'b0;
    ram_raddr = '0;
    en_nxt    = en_r;
    head_nxt  = head_r;
    cnt_nxt   = cnt_r;
    q_nxt     = q_r;
    hsnap_nxt = hsnap_r;
    cur_nxt   = cur_r;
    key_nxt   = key_r;
    cnt_q_nxt = cnt_q_r;
    res_nxt   = res_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          q_nxt     = qi;
          hsnap_nxt = hd;
          key_nxt   = in_data.address;
          res_nxt   = '0;
          if (!en_hit) begin
            res_nxt.status = STAT_DISABLED;
          end else begin
            case (in_data.req_type)
              REQ_PUSH: begin
                if (full) begin
                  res_nxt.status = STAT_FULL;
                  res_nxt.count  = 5'(n);
                end else begin
                  ram_we         = 1'b1;
                  cnt_nxt[qi]    = n + CNT_ONE;
                  res_nxt.status = STAT_OK;
                  res_nxt.count  = 5'(n + CNT_ONE);
                end
              end
              REQ_POP, REQ_PEEK: begin
                if (empty) begin
                  res_nxt.status = STAT_EMPTY;
                end else begin
                  ram_re    = 1'b1;
                  ram_raddr = slot_of(qi, hd, '0);
                  if (in_data.req_type == REQ_POP) begin
                    head_nxt[qi] = ring_add(hd, HEAD_W'(1));
                    cnt_nxt[qi]  = n - CNT_ONE;
                    cnt_q_nxt    = n - CNT_ONE;
                  end else begin
                    cnt_q_nxt = n;
                  end
                end
              end
              REQ_FIND: begin
                // The walk starts at the tail so the first match is the newest.
                res_nxt.status = STAT_OK;
                if (!empty) begin
                  ram_re    = 1'b1;
                  ram_raddr = slot_of(qi, hd, HEAD_W'(n - CNT_ONE));
                  cur_nxt   = HEAD_W'(n - CNT_ONE);
                  cnt_q_nxt = n;
                end
              end
              default: ;
            endcase
          end
        end
      end
      S_READ: begin
        res_nxt             = '0;
        res_nxt.status      = STAT_OK;
        res_nxt.found       = 1'b1;
        res_nxt.out_address = ram_rdata.address;
        res_nxt.out_tag     = ram_rdata.tag;
        res_nxt.count       = 5'(cnt_q_r);
      end
      S_SEARCH: begin
        res_nxt        = '0;
        res_nxt.status = STAT_OK;
        res_nxt.count  = 5'(cnt_q_r);
        if (srch_hit) begin
          res_nxt.found       = 1'b1;
          res_nxt.out_address = ram_rdata.address;
          res_nxt.out_tag     = ram_rdata.tag;
          res_nxt.position    = 4'(cur_r);
        end else if (!srch_last) begin
          ram_re    = 1'b1;
          ram_raddr = slot_of(q_r, hsnap_r, cur_r - HEAD_W'(1));
          cur_nxt   = cur_r - HEAD_W'(1);
        end
      end
      S_DONE: ;
      default: ;
    endcase
    // A queue that becomes enabled starts out empty.
    if (cfg_we) begin
      en_nxt = cfg_wdata;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        if (rise[i]) begin
          head_nxt[i] = '0;
          cnt_nxt[i]  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      en_r    <= '0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      en_r    <= en_nxt;
      head_r  <= head_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r     <= q_nxt;
    hsnap_r <= hsnap_nxt;
    cur_r   <= cur_nxt;
    key_r   <= key_nxt;
    cnt_q_r <= cnt_q_nxt;
    res_r   <= res_nxt;
  end

  `MQF_ASSERT_IMP(a_we_on_accept, clk, rst_n, ram_we, in_acc, "slot write without accepted push")
  `MQF_ASSERT_IMP(a_cursor_range, clk, rst_n, state_r == S_SEARCH, CNT_W'(cur_r) < cnt_q_r, "search cursor beyond queue count")
  `MQF_ASSERT_NXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_r), "pending result changed")

endmodule

>>> rtl/multi_queue_fifo_with_address_search_unit.sv
// Usage:
// Several FIFO queues share one slot memory. A transaction on the in_ channel
// pushes, pops, peeks at the head of, or searches one queue for the newest
// entry with a given address; every transaction yields exactly one result
// transaction on the out_ channel with status and queue count (0 if disabled).
// cfg_we/cfg_wdata write the queue enable mask; a queue whose bit rises is
// emptied. Write it only while no transaction is in flight.
// A push, an error or a search of an empty queue goes straight from input
// accept to the result; pop and peek first read the head slot, and a search
// reads up to QUEUE_DEPTH entries, newest first, until a match. A new input
// is taken only after the previous result has been loaded into the output
// register. The search cost comes from the single read port of the slot
// memory, which the search walk reads one entry per cycle.
// A result waits in the output register while out_stall is high, and the
// block can meanwhile accept and work on the next transaction.
// Reset (rst_n low, synchronous) disables all queues, empties them and
// drops any pending result; slot contents are not cleared.
`include "multi_queue_fifo_with_address_search_unit_macros.svh"

module multi_queue_fifo_with_address_search_unit import mqf_pkg::*; #(
  parameter int NUM_QUEUES  = 4,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata
);

  localparam int SLOT_TOTAL = NUM_QUEUES * QUEUE_DEPTH;
  localparam int SLOT_W     = $clog2(SLOT_TOTAL);

  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  slot_t             ram_wdata;
  logic              ram_re;
  logic [SLOT_W-1:0] ram_raddr;
  slot_t             ram_rdata;
  logic              res_valid;
  logic              res_ready;
  out_item_t         res_data;
  logic              res_load;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r;

  mqf_ctrl #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  mqf_slot_ram #(
    .SLOTS (SLOT_TOTAL)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The output register takes a new result when empty or being drained.
  assign res_ready = !out_valid_r || !out_stall;
  assign res_load  = res_valid && res_ready;

  always_comb begin
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `MQF_ASSERT_IMP(a_nofound_zero, clk, rst_n, out_valid && !out_data.found, out_data.out_address == '0 && out_data.out_tag == '0 && out_data.position == '0, "entry fields set without found")
  `MQF_ASSERT_IMP(a_err_nofound, clk, rst_n, out_valid && out_data.status != STAT_OK, !out_data.found, "error status with found entry")
  `MQF_ASSERT_IMP(a_dis_count, clk, rst_n, out_valid && out_data.status == STAT_DISABLED, out_data.count == '0, "disabled queue reports a count")

endmodule
